// File: rtl/ctsb_pkg.sv
// ----------------------------------------------------------------------------
// ctsb_pkg
// Shared types and codes for the countdown timer slot bank.
// ----------------------------------------------------------------------------
package ctsb_pkg;

    localparam int unsigned SLOT_W  = 4;
    localparam int unsigned COUNT_W = 32;
    localparam int unsigned MASK_W  = 16;

    // request function codes
    localparam logic [1:0] FN_TICK    = 2'd0;
    localparam logic [1:0] FN_ALLOC   = 2'd1;
    localparam logic [1:0] FN_RELEASE = 2'd2;

    // response status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_FULL       = 2'd1;
    localparam logic [1:0] ST_NOT_ACTIVE = 2'd2;

    typedef struct packed {
        logic [1:0]         func;
        logic [COUNT_W-1:0] delay;
        logic [SLOT_W-1:0]  slot;
    } t_req;

    typedef struct packed {
        logic [1:0]        status;
        logic [SLOT_W-1:0] granted_slot;
        logic [MASK_W-1:0] expired_mask;
        logic [MASK_W-1:0] ready_mask;
    } t_rsp;

    // command broadcast to every cell
    typedef struct packed {
        logic               exec;
        logic [1:0]         func;
        logic [COUNT_W-1:0] delay;
        logic [SLOT_W-1:0]  slot;
    } t_cmd;

    // data handed from one cell to the next
    typedef struct packed {
        logic              taken;
        logic [SLOT_W-1:0] idx;
        logic              hit;
    } t_chain;

endpackage

// File: rtl/countdown_timer_slot_bank_top.sv
// ----------------------------------------------------------------------------
// countdown_timer_slot_bank_top
// Bank of countdown timer slots built as a row of slot cells.
// ----------------------------------------------------------------------------
// Each request passes from acceptance to a valid response through S_IDLE,
// which registers the request, S_EXEC, in which every slot cell applies it
// (the tick decrements every active slot with a nonzero count at once, the
// allocate search and the release match ripple along the row of cells), and
// S_LOAD, which loads the output register once it is free. A new request is
// accepted as soon as the previous one has reached the output register, so
// a response may wait there while the next request is being worked on.
// Masks carry one bit per slot, bits at or above NUM_SLOTS read zero.
module countdown_timer_slot_bank_top
    import ctsb_pkg::*;
#(
    parameter int unsigned NUM_SLOTS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_req i_in_req,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_rsp o_out_rsp
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_LOAD
    } t_state;

    localparam logic [MASK_W-1:0] SLOT_MASK = MASK_W'((64'd1 << NUM_SLOTS) - 64'd1);

    t_state r_state;
    t_req   r_req;
    logic   [1:0] r_status;
    logic   [SLOT_W-1:0] r_granted;
    logic   r_out_valid;
    t_rsp   r_out_rsp;

    t_cmd   cmd;
    t_chain chain [0:NUM_SLOTS];
    logic   [NUM_SLOTS-1:0] ready_bits;
    logic   [NUM_SLOTS-1:0] expired_bits;
    logic   [1:0] exec_status;
    logic   [SLOT_W-1:0] exec_granted;
    logic   in_take;
    logic   out_free;

    assign in_take  = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        cmd.exec  = (r_state == S_EXEC);
        cmd.func  = r_req.func;
        cmd.delay = r_req.delay;
        cmd.slot  = r_req.slot;
    end

    assign chain[0] = '0;

    for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
        ctsb_cell #(
            .IDX(g)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_cmd     (cmd),
            .i_chain   (chain[g]),
            .o_chain   (chain[g+1]),
            .o_ready   (ready_bits[g]),
            .o_expired (expired_bits[g])
        );
    end

    always_comb begin
        exec_status  = ST_OK;
        exec_granted = '0;
        case (r_req.func)
            FN_ALLOC: begin
                if (chain[NUM_SLOTS].taken) begin
                    exec_granted = chain[NUM_SLOTS].idx;
                end else begin
                    exec_status = ST_FULL;
                end
            end
            FN_RELEASE: begin
                if (!chain[NUM_SLOTS].hit) begin
                    exec_status = ST_NOT_ACTIVE;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // in S_LOAD the case below decides the output valid
            if (r_out_valid && !i_out_stall && (r_state != S_LOAD)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_take) begin
                        r_req   <= i_in_req;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_status  <= exec_status;
                    r_granted <= exec_granted;
                    r_state   <= S_LOAD;
                end
                S_LOAD: begin
                    // hold until the output register can take the response
                    if (out_free) begin
                        r_out_rsp.status       <= r_status;
                        r_out_rsp.granted_slot <= r_granted;
                        r_out_rsp.expired_mask <= MASK_W'(expired_bits);
                        r_out_rsp.ready_mask   <= MASK_W'(ready_bits);
                        r_out_valid            <= 1'b1;
                        r_state                <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out_rsp;

    // a slot reported expired is also reported ready
    a_expired_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_rsp.expired_mask & ~o_out_rsp.ready_mask) == '0))
        else $error("expired slot not ready");

    a_full_no_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_rsp.status == ST_FULL)) |-> (o_out_rsp.granted_slot == '0))
        else $error("grant on full bank");

    a_mask_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (((o_out_rsp.ready_mask | o_out_rsp.expired_mask) & ~SLOT_MASK) == '0))
        else $error("mask bit beyond bank size");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_EXEC))
        else $error("accepted request not executed");

endmodule

// File: rtl/ctsb_cell.sv
// ----------------------------------------------------------------------------
// ctsb_cell
// One timer slot: count, active, ready and expired flags, plus its link in the
// free-slot search and release match chain.
// ----------------------------------------------------------------------------
module ctsb_cell
    import ctsb_pkg::*;
#(
    parameter int unsigned IDX = 0
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_cmd   i_cmd,
    input  t_chain i_chain,
    output t_chain o_chain,
    output logic   o_ready,
    output logic   o_expired
);

    localparam logic [SLOT_W-1:0] ID = SLOT_W'(IDX);

    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] n_count;
    logic               r_active;
    logic               n_active;
    logic               r_ready;
    logic               n_ready;
    logic               r_expired;
    logic               n_expired;

    logic claim;
    logic match;

    // first inactive cell on the chain claims the allocate
    assign claim = !i_chain.taken && !r_active;
    assign match = (i_cmd.slot == ID) && r_active;

    always_comb begin
        o_chain.taken = i_chain.taken || !r_active;
        o_chain.idx   = claim ? ID : i_chain.idx;
        o_chain.hit   = i_chain.hit || match;
    end

    always_comb begin
        n_count   = r_count;
        n_active  = r_active;
        n_ready   = r_ready;
        n_expired = r_expired;
        if (i_cmd.exec) begin
            n_expired = 1'b0;
            case (i_cmd.func)
                FN_TICK: begin
                    if (r_active && (r_count != '0)) begin
                        n_count = r_count - COUNT_W'(1);
                        if (r_count == COUNT_W'(1)) begin
                            n_ready   = 1'b1;
                            n_expired = 1'b1;
                        end
                    end
                end
                FN_ALLOC: begin
                    if (claim) begin
                        n_count  = i_cmd.delay;
                        n_active = 1'b1;
                        n_ready  = 1'b0;
                    end
                end
                FN_RELEASE: begin
                    if (match) begin
                        n_count  = '0;
                        n_active = 1'b0;
                        n_ready  = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_active  <= 1'b0;
            r_ready   <= 1'b0;
            r_expired <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_active  <= n_active;
            r_ready   <= n_ready;
            r_expired <= n_expired;
        end
    end

    assign o_ready   = r_ready;
    assign o_expired = r_expired;

endmodule
